/* hw/rtl/tgc_pkg.sv */
// shared types and constants of the touch gesture classifier
// used by every module under hw/rtl, no dependencies
`default_nettype none

package tgc_pkg;

    localparam int GRID_COLS = 79;
    localparam int GRID_ROWS = 29;
    localparam logic [15:0] TAN_Q16 = 16'd27146;

    localparam int DIV_NW = 24;
    localparam int DIV_DW = 16;
    localparam int DIV_CW = 5;

    localparam logic [2:0] MODE_POLL  = 3'd0;
    localparam logic [2:0] MODE_DOWN  = 3'd1;
    localparam logic [2:0] MODE_MOVE  = 3'd2;
    localparam logic [2:0] MODE_UP    = 3'd3;
    localparam logic [2:0] MODE_RESET = 3'd4;

    localparam logic [2:0] EV_DOWN  = 3'd0;
    localparam logic [2:0] EV_UP    = 3'd1;
    localparam logic [2:0] EV_RDOWN = 3'd2;
    localparam logic [2:0] EV_HOVER = 3'd3;
    localparam logic [2:0] EV_KEY   = 3'd4;

    localparam logic [7:0] KEY_E   = 8'd0;
    localparam logic [7:0] KEY_NE  = 8'd1;
    localparam logic [7:0] KEY_N   = 8'd2;
    localparam logic [7:0] KEY_NW  = 8'd3;
    localparam logic [7:0] KEY_W   = 8'd4;
    localparam logic [7:0] KEY_SW  = 8'd5;
    localparam logic [7:0] KEY_S   = 8'd6;
    localparam logic [7:0] KEY_SE  = 8'd7;
    localparam logic [7:0] KEY_ESC = 8'd8;

    localparam logic [2:0] CFG_WIN_W   = 3'd0;
    localparam logic [2:0] CFG_WIN_H   = 3'd1;
    localparam logic [2:0] CFG_ZOOM    = 3'd2;
    localparam logic [2:0] CFG_UI      = 3'd3;
    localparam logic [2:0] CFG_LONG    = 3'd4;
    localparam logic [2:0] CFG_TAP     = 3'd5;
    localparam logic [2:0] CFG_SWIPE   = 3'd6;
    localparam logic [2:0] CFG_TWO_TAP = 3'd7;

    typedef enum logic [4:0] {
        GS_IDLE    = 5'b00001,
        GS_DOWN    = 5'b00010,
        GS_SWIPE   = 5'b00100,
        GS_INSPECT = 5'b01000,
        GS_TWO     = 5'b10000
    } gst_t;

    typedef struct packed {
        logic capture;
        logic sq_x;
        logic sq_y;
        logic sq_tap;
        logic sq_swp;
        logic tan_x;
        logic tan_y;
        logic fit_start;
        logic fit_take;
        logic zoom_w;
        logic zoom_h;
        logic ofs;
        logic num_x;
        logic div_x;
        logic col_take;
        logic num_y;
        logic div_y;
        logic row_take;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic need_cell;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/tgc_div.sv */
// restoring divider, one quotient bit per cycle
// depends on tgc_pkg
`default_nettype none

module tgc_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [tgc_pkg::DIV_NW-1:0] dividend,
    input  wire logic [tgc_pkg::DIV_DW-1:0] divisor,
    output logic      [tgc_pkg::DIV_NW-1:0] quotient,
    output logic                            done
);

    logic [tgc_pkg::DIV_DW-1:0] rem_reg, rem_next;
    logic [tgc_pkg::DIV_NW-1:0] quo_reg, quo_next;
    logic [tgc_pkg::DIV_DW-1:0] dvs_reg, dvs_next;
    logic [tgc_pkg::DIV_CW-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [tgc_pkg::DIV_DW:0]   rem_sh;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, quo_reg[tgc_pkg::DIV_NW-1]};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = tgc_pkg::DIV_CW'(tgc_pkg::DIV_NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next = tgc_pkg::DIV_DW'(rem_sh - {1'b0, dvs_reg});
                quo_next = {quo_reg[tgc_pkg::DIV_NW-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[tgc_pkg::DIV_DW-1:0];
                quo_next = {quo_reg[tgc_pkg::DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == tgc_pkg::DIV_CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && !done_reg)
        else $error("divider did not start");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");

endmodule

`default_nettype wire

/* hw/rtl/tgc_dp.sv */
// datapath: config registers, gesture state, multiplier, cell mapping and result register
// depends on tgc_pkg and tgc_div
`default_nettype none

module tgc_dp (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire tgc_pkg::cmd_t cmd,
    output tgc_pkg::sts_t      sts,
    input  wire logic [71:0]   s_tdata,
    input  wire logic [2:0]    s_tuser,
    output logic [23:0]        m_tdata,
    output logic [2:0]         m_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire logic          cfg_valid,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [15:0]   cfg_data
);

    // configuration
    logic [11:0] win_w_reg, win_h_reg, zoom_reg, tap_reg, swp_reg;
    logic [15:0] lp_reg, tt_reg;
    logic        ui_reg;

    // captured item
    logic [2:0]  mode_reg;
    logic [15:0] id_reg;
    logic [11:0] px_reg, py_reg;
    logic [31:0] stamp_reg;

    // gesture state
    tgc_pkg::gst_t gst_reg, gst_next;
    logic [11:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [31:0] t0_reg, t0_next;
    logic [15:0] id1_reg, id1_next, id2_reg, id2_next;
    logic [11:0] f1x_reg, f1x_next, f1y_reg, f1y_next;
    logic [11:0] f2x_reg, f2x_next, f2y_reg, f2y_next;
    logic [12:0] midx_reg, midx_next, midy_reg, midy_next;
    logic signed [16:0] panx_reg, panx_next, pany_reg, pany_next;
    logic        hold_reg, hold_next, owed_reg, owed_next;
    logic [7:0]  owc_reg, owc_next, owr_reg, owr_next;

    // work registers
    logic [24:0] dist_reg;
    logic [23:0] tapsq_reg, swpsq_reg;
    logic [27:0] tx_reg, ty_reg;
    logic [11:0] fw_reg, fh_reg;
    logic [15:0] w_reg, h_reg;
    logic signed [19:0] ox_reg, oy_reg;
    logic [23:0] num_reg;
    logic        neg_reg;
    logic [7:0]  col_reg, row_reg;

    // result register
    logic        mv_reg, rv_reg, rp_reg;
    logic [2:0]  rk_reg;
    logic [7:0]  ra_reg, rb_reg;

    logic [11:0] w_eff, h_eff, zeff, adx, ady, map_x, map_y;
    logic signed [12:0] dxs, dys;
    logic [12:0] ndx, ndy;
    logic        idm, long_ok, run;
    logic [31:0] elapsed;
    logic [16:0] mul_a;
    logic [15:0] mul_b;
    logic [32:0] mul_p;
    logic        div_start, div_done;
    logic [23:0] div_n, div_q;
    logic [15:0] div_d;
    logic [15:0] w10;
    logic [11:0] fw_n, fh_n;
    logic signed [20:0] diff;
    logic [7:0]  cell_q;
    logic        r_valid;
    logic [2:0]  r_kind;
    logic [7:0]  r_a1, r_a2;
    logic [11:0] f1x_u, f1y_u, f2x_u, f2y_u;
    logic [12:0] mx, my;

    function automatic logic signed [19:0] axis_ofs(input logic [11:0] full,
                                                    input logic [15:0] len,
                                                    input logic signed [16:0] pan,
                                                    input logic ui);
        logic signed [19:0] d, hd, ph, o;
        d  = $signed({8'd0, full}) - $signed({4'd0, len});
        hd = d + $signed({19'd0, d[19]});
        hd = hd >>> 1;
        ph = {{3{pan[16]}}, pan};
        ph = ph + $signed({19'd0, ph[19]});
        ph = ph >>> 1;
        if (ui) begin
            o = hd;
        end else begin
            o = hd + ph;
            if (o > 20'sd0) o = 20'sd0;
            if (o < d) o = d;
        end
        return o;
    endfunction

    function automatic logic signed [16:0] pan_add(input logic signed [16:0] p,
                                                   input logic [12:0] nw,
                                                   input logic [12:0] old);
        logic signed [17:0] v;
        v = {p[16], p} + $signed({5'd0, nw}) - $signed({5'd0, old});
        if (v > 18'sd65535) v = 18'sd65535;
        if (v < -18'sd65536) v = -18'sd65536;
        return v[16:0];
    endfunction

    function automatic logic [7:0] swipe_key(input logic [11:0] ax, input logic [11:0] ay,
                                             input logic [27:0] tx, input logic [27:0] ty,
                                             input logic ux_neg, input logic uy_pos);
        logic [7:0] k;
        if ((ax == 12'd0 && ay == 12'd0) || ({ay, 16'd0} < tx)) begin
            k = ux_neg ? tgc_pkg::KEY_W : tgc_pkg::KEY_E;
        end else if ({ax, 16'd0} <= ty) begin
            k = uy_pos ? tgc_pkg::KEY_N : tgc_pkg::KEY_S;
        end else if (!ux_neg) begin
            k = uy_pos ? tgc_pkg::KEY_NE : tgc_pkg::KEY_SE;
        end else begin
            k = uy_pos ? tgc_pkg::KEY_NW : tgc_pkg::KEY_SW;
        end
        return k;
    endfunction

    assign w_eff = (win_w_reg == 12'd0) ? 12'd1 : win_w_reg;
    assign h_eff = (win_h_reg == 12'd0) ? 12'd1 : win_h_reg;
    assign zeff  = (zoom_reg < 12'd256) ? 12'd256 : zoom_reg;

    assign dxs = $signed({1'b0, px_reg}) - $signed({1'b0, sx_reg});
    assign dys = $signed({1'b0, py_reg}) - $signed({1'b0, sy_reg});
    assign ndx = -dxs;
    assign ndy = -dys;
    assign adx = dxs[12] ? ndx[11:0] : dxs[11:0];
    assign ady = dys[12] ? ndy[11:0] : dys[11:0];

    assign idm     = (id_reg == id1_reg);
    assign elapsed = stamp_reg - t0_reg;
    assign long_ok = (elapsed >= {16'd0, lp_reg});
    assign run     = (mode_reg != tgc_pkg::MODE_RESET) && !owed_reg;

    assign map_x = (mode_reg == tgc_pkg::MODE_UP && gst_reg == tgc_pkg::GS_DOWN) ? sx_reg : px_reg;
    assign map_y = (mode_reg == tgc_pkg::MODE_UP && gst_reg == tgc_pkg::GS_DOWN) ? sy_reg : py_reg;

    assign sts.need_cell = run && idm &&
        ((mode_reg == tgc_pkg::MODE_MOVE &&
          ((gst_reg == tgc_pkg::GS_DOWN && long_ok) || gst_reg == tgc_pkg::GS_INSPECT)) ||
         (mode_reg == tgc_pkg::MODE_UP &&
          (gst_reg == tgc_pkg::GS_DOWN || gst_reg == tgc_pkg::GS_INSPECT)));
    assign sts.div_done = div_done;
    assign sts.out_free = !mv_reg || m_tready;

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.sq_x) begin
            mul_a = {5'd0, adx};
            mul_b = {4'd0, adx};
        end else if (cmd.sq_y) begin
            mul_a = {5'd0, ady};
            mul_b = {4'd0, ady};
        end else if (cmd.sq_tap) begin
            mul_a = {5'd0, tap_reg};
            mul_b = {4'd0, tap_reg};
        end else if (cmd.sq_swp) begin
            mul_a = {5'd0, swp_reg};
            mul_b = {4'd0, swp_reg};
        end else if (cmd.tan_x) begin
            mul_a = {5'd0, adx};
            mul_b = tgc_pkg::TAN_Q16;
        end else if (cmd.tan_y) begin
            mul_a = {5'd0, ady};
            mul_b = tgc_pkg::TAN_Q16;
        end else if (cmd.zoom_w) begin
            mul_a = {5'd0, fw_reg};
            mul_b = {4'd0, zeff};
        end else if (cmd.zoom_h) begin
            mul_a = {5'd0, fh_reg};
            mul_b = {4'd0, zeff};
        end else if (cmd.num_x || cmd.num_y) begin
            mul_a = diff[16:0];
            mul_b = cmd.num_x ? 16'(tgc_pkg::GRID_COLS) : 16'(tgc_pkg::GRID_ROWS);
        end
    end
    assign mul_p = mul_a * mul_b;

    assign diff = cmd.num_x ? ($signed({9'd0, map_x}) - {ox_reg[19], ox_reg})
                            : ($signed({9'd0, map_y}) - {oy_reg[19], oy_reg});

    // fit size
    assign w10 = ({4'd0, w_eff} << 3) + ({4'd0, w_eff} << 1);
    always_comb begin
        if (div_q[12:0] > {1'b0, w_eff}) begin
            fw_n = w_eff;
            fh_n = w10[15:4];
        end else begin
            fw_n = div_q[11:0];
            fh_n = h_eff;
        end
        if (fw_n == 12'd0) fw_n = 12'd1;
        if (fh_n == 12'd0) fh_n = 12'd1;
    end

    assign div_start = cmd.fit_start || cmd.div_x || cmd.div_y;
    assign div_n     = cmd.fit_start ? {8'd0, h_eff, 4'd0} : num_reg;
    assign div_d     = cmd.fit_start ? 16'd10 : (cmd.div_x ? w_reg : h_reg);

    tgc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .quotient (div_q),
        .done     (div_done)
    );

    always_comb begin
        if (neg_reg) begin
            cell_q = 8'd0;
        end else if (cmd.col_take) begin
            cell_q = (div_q >= 24'(tgc_pkg::GRID_COLS)) ? 8'(tgc_pkg::GRID_COLS - 1) : div_q[7:0];
        end else begin
            cell_q = (div_q >= 24'(tgc_pkg::GRID_ROWS)) ? 8'(tgc_pkg::GRID_ROWS - 1) : div_q[7:0];
        end
    end

    // step update
    always_comb begin
        gst_next  = gst_reg;
        sx_next   = sx_reg;
        sy_next   = sy_reg;
        t0_next   = t0_reg;
        id1_next  = id1_reg;
        id2_next  = id2_reg;
        f1x_next  = f1x_reg;
        f1y_next  = f1y_reg;
        f2x_next  = f2x_reg;
        f2y_next  = f2y_reg;
        midx_next = midx_reg;
        midy_next = midy_reg;
        panx_next = panx_reg;
        pany_next = pany_reg;
        hold_next = hold_reg;
        owed_next = owed_reg;
        owc_next  = owc_reg;
        owr_next  = owr_reg;
        r_valid   = 1'b0;
        r_kind    = tgc_pkg::EV_DOWN;
        r_a1      = 8'd0;
        r_a2      = 8'd0;
        f1x_u     = f1x_reg;
        f1y_u     = f1y_reg;
        f2x_u     = f2x_reg;
        f2y_u     = f2y_reg;
        if (idm) begin
            f1x_u = px_reg;
            f1y_u = py_reg;
        end else if (id_reg == id2_reg) begin
            f2x_u = px_reg;
            f2y_u = py_reg;
        end
        mx = {1'b0, f1x_u} + {1'b0, f2x_u};
        my = {1'b0, f1y_u} + {1'b0, f2y_u};
        if (mode_reg == tgc_pkg::MODE_RESET) begin
            gst_next  = tgc_pkg::GS_IDLE;
            owed_next = 1'b0;
        end else if (owed_reg) begin
            owed_next = 1'b0;
            r_valid   = 1'b1;
            r_kind    = tgc_pkg::EV_UP;
            r_a1      = owc_reg;
            r_a2      = owr_reg;
        end else begin
            case (mode_reg)
                tgc_pkg::MODE_DOWN: begin
                    if (gst_reg == tgc_pkg::GS_IDLE) begin
                        gst_next = tgc_pkg::GS_DOWN;
                        id1_next = id_reg;
                        sx_next  = px_reg;
                        sy_next  = py_reg;
                        t0_next  = stamp_reg;
                    end else if (gst_reg == tgc_pkg::GS_DOWN) begin
                        gst_next  = tgc_pkg::GS_TWO;
                        hold_next = 1'b1;
                        id2_next  = id_reg;
                        f1x_next  = sx_reg;
                        f1y_next  = sy_reg;
                        f2x_next  = px_reg;
                        f2y_next  = py_reg;
                        midx_next = {1'b0, sx_reg} + {1'b0, px_reg};
                        midy_next = {1'b0, sy_reg} + {1'b0, py_reg};
                    end
                end
                tgc_pkg::MODE_MOVE: begin
                    if (gst_reg == tgc_pkg::GS_DOWN && idm) begin
                        if (long_ok) begin
                            gst_next = tgc_pkg::GS_INSPECT;
                            r_valid  = 1'b1;
                            r_kind   = tgc_pkg::EV_HOVER;
                            r_a1     = col_reg;
                            r_a2     = row_reg;
                        end else if (dist_reg > {1'b0, tapsq_reg}) begin
                            gst_next = tgc_pkg::GS_SWIPE;
                        end
                    end else if (gst_reg == tgc_pkg::GS_INSPECT && idm) begin
                        r_valid = 1'b1;
                        r_kind  = tgc_pkg::EV_HOVER;
                        r_a1    = col_reg;
                        r_a2    = row_reg;
                    end else if (gst_reg == tgc_pkg::GS_TWO) begin
                        f1x_next  = f1x_u;
                        f1y_next  = f1y_u;
                        f2x_next  = f2x_u;
                        f2y_next  = f2y_u;
                        panx_next = pan_add(panx_reg, mx, midx_reg);
                        pany_next = pan_add(pany_reg, my, midy_reg);
                        midx_next = mx;
                        midy_next = my;
                    end
                end
                tgc_pkg::MODE_UP: begin
                    if (gst_reg == tgc_pkg::GS_DOWN && idm) begin
                        if (dist_reg <= {1'b0, tapsq_reg}) begin
                            r_valid = 1'b1;
                            r_a1    = col_reg;
                            r_a2    = row_reg;
                            if (long_ok) begin
                                r_kind = tgc_pkg::EV_RDOWN;
                            end else begin
                                r_kind    = tgc_pkg::EV_DOWN;
                                owed_next = 1'b1;
                                owc_next  = col_reg;
                                owr_next  = row_reg;
                            end
                        end
                    end else if (gst_reg == tgc_pkg::GS_SWIPE && idm) begin
                        if (dist_reg >= {1'b0, swpsq_reg}) begin
                            r_valid = 1'b1;
                            r_kind  = tgc_pkg::EV_KEY;
                            r_a1    = swipe_key(adx, ady, tx_reg, ty_reg,
                                                px_reg < sx_reg, py_reg < sy_reg);
                        end
                    end else if (gst_reg == tgc_pkg::GS_INSPECT && idm) begin
                        r_valid   = 1'b1;
                        r_kind    = tgc_pkg::EV_DOWN;
                        r_a1      = col_reg;
                        r_a2      = row_reg;
                        owed_next = 1'b1;
                        owc_next  = col_reg;
                        owr_next  = row_reg;
                    end else if (gst_reg == tgc_pkg::GS_TWO) begin
                        hold_next = 1'b0;
                        if (elapsed <= {16'd0, tt_reg}) begin
                            r_valid = 1'b1;
                            r_kind  = tgc_pkg::EV_KEY;
                            r_a1    = tgc_pkg::KEY_ESC;
                        end
                    end
                    gst_next = tgc_pkg::GS_IDLE;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_w_reg <= 12'd1920;
            win_h_reg <= 12'd1080;
            zoom_reg  <= 12'd512;
            ui_reg    <= 1'b0;
            lp_reg    <= 16'd400;
            tap_reg   <= 12'd20;
            swp_reg   <= 12'd40;
            tt_reg    <= 16'd200;
        end else if (cfg_valid) begin
            case (cfg_index)
                tgc_pkg::CFG_WIN_W:   win_w_reg <= cfg_data[11:0];
                tgc_pkg::CFG_WIN_H:   win_h_reg <= cfg_data[11:0];
                tgc_pkg::CFG_ZOOM:    zoom_reg  <= cfg_data[11:0];
                tgc_pkg::CFG_UI:      ui_reg    <= cfg_data[0];
                tgc_pkg::CFG_LONG:    lp_reg    <= cfg_data;
                tgc_pkg::CFG_TAP:     tap_reg   <= cfg_data[11:0];
                tgc_pkg::CFG_SWIPE:   swp_reg   <= cfg_data[11:0];
                tgc_pkg::CFG_TWO_TAP: tt_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gst_reg  <= tgc_pkg::GS_IDLE;
            sx_reg   <= '0;
            sy_reg   <= '0;
            t0_reg   <= '0;
            id1_reg  <= '0;
            id2_reg  <= '0;
            f1x_reg  <= '0;
            f1y_reg  <= '0;
            f2x_reg  <= '0;
            f2y_reg  <= '0;
            midx_reg <= '0;
            midy_reg <= '0;
            panx_reg <= '0;
            pany_reg <= '0;
            hold_reg <= 1'b0;
            owed_reg <= 1'b0;
            owc_reg  <= '0;
            owr_reg  <= '0;
            mv_reg   <= 1'b0;
        end else begin
            if (cmd.commit) begin
                gst_reg  <= gst_next;
                sx_reg   <= sx_next;
                sy_reg   <= sy_next;
                t0_reg   <= t0_next;
                id1_reg  <= id1_next;
                id2_reg  <= id2_next;
                f1x_reg  <= f1x_next;
                f1y_reg  <= f1y_next;
                f2x_reg  <= f2x_next;
                f2y_reg  <= f2y_next;
                midx_reg <= midx_next;
                midy_reg <= midy_next;
                panx_reg <= panx_next;
                pany_reg <= pany_next;
                hold_reg <= hold_next;
                owed_reg <= owed_next;
                owc_reg  <= owc_next;
                owr_reg  <= owr_next;
                mv_reg   <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= s_tuser;
            id_reg    <= s_tdata[15:0];
            px_reg    <= s_tdata[27:16];
            py_reg    <= s_tdata[39:28];
            stamp_reg <= s_tdata[71:40];
        end
        if (cmd.sq_x)   dist_reg  <= mul_p[24:0];
        if (cmd.sq_y)   dist_reg  <= dist_reg + mul_p[24:0];
        if (cmd.sq_tap) tapsq_reg <= mul_p[23:0];
        if (cmd.sq_swp) swpsq_reg <= mul_p[23:0];
        if (cmd.tan_x)  tx_reg    <= mul_p[27:0];
        if (cmd.tan_y)  ty_reg    <= mul_p[27:0];
        if (cmd.fit_take) begin
            fw_reg <= fw_n;
            fh_reg <= fh_n;
        end
        if (cmd.zoom_w) w_reg <= ui_reg ? {4'd0, fw_reg} : mul_p[23:8];
        if (cmd.zoom_h) h_reg <= ui_reg ? {4'd0, fh_reg} : mul_p[23:8];
        if (cmd.ofs) begin
            ox_reg <= axis_ofs(w_eff, w_reg, panx_reg, ui_reg);
            oy_reg <= axis_ofs(h_eff, h_reg, pany_reg, ui_reg);
        end
        if (cmd.num_x || cmd.num_y) begin
            num_reg <= mul_p[23:0];
            neg_reg <= diff[20];
        end
        if (cmd.col_take) col_reg <= cell_q;
        if (cmd.row_take) row_reg <= cell_q;
        if (cmd.commit) begin
            rv_reg <= r_valid;
            rk_reg <= r_kind;
            ra_reg <= r_a1;
            rb_reg <= r_a2;
            rp_reg <= hold_next;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {6'd0, rp_reg, rb_reg, ra_reg, rv_reg};
    assign m_tuser  = rk_reg;

    a_owed_after_down: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(owed_reg) |-> mv_reg && rv_reg && rk_reg == tgc_pkg::EV_DOWN)
        else $error("owed up without a preceding down");
    a_hold_two: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(hold_reg) |-> gst_reg == tgc_pkg::GS_TWO)
        else $error("pan hold outside two finger state");

endmodule

`default_nettype wire

/* hw/rtl/tgc_ctrl.sv */
// sequencer of the gesture classifier, drives the datapath step by step
// depends on tgc_pkg
`default_nettype none

module tgc_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire tgc_pkg::sts_t sts,
    output tgc_pkg::cmd_t      cmd
);

    typedef enum logic [18:0] {
        ST_IDLE = 19'd1 << 0,
        ST_SQX  = 19'd1 << 1,
        ST_SQY  = 19'd1 << 2,
        ST_TAP  = 19'd1 << 3,
        ST_SWP  = 19'd1 << 4,
        ST_TNX  = 19'd1 << 5,
        ST_TNY  = 19'd1 << 6,
        ST_FIT  = 19'd1 << 7,
        ST_FITW = 19'd1 << 8,
        ST_ZW   = 19'd1 << 9,
        ST_ZH   = 19'd1 << 10,
        ST_OFS  = 19'd1 << 11,
        ST_NX   = 19'd1 << 12,
        ST_DXS  = 19'd1 << 13,
        ST_DXW  = 19'd1 << 14,
        ST_NY   = 19'd1 << 15,
        ST_DYS  = 19'd1 << 16,
        ST_DYW  = 19'd1 << 17,
        ST_OUTW = 19'd1 << 18
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SQX;
                end
            end
            ST_SQX: begin
                cmd.sq_x   = 1'b1;
                state_next = ST_SQY;
            end
            ST_SQY: begin
                cmd.sq_y   = 1'b1;
                state_next = ST_TAP;
            end
            ST_TAP: begin
                cmd.sq_tap = 1'b1;
                state_next = ST_SWP;
            end
            ST_SWP: begin
                cmd.sq_swp = 1'b1;
                state_next = ST_TNX;
            end
            ST_TNX: begin
                cmd.tan_x  = 1'b1;
                state_next = ST_TNY;
            end
            ST_TNY: begin
                cmd.tan_y  = 1'b1;
                state_next = sts.need_cell ? ST_FIT : ST_OUTW;
            end
            ST_FIT: begin
                cmd.fit_start = 1'b1;
                state_next    = ST_FITW;
            end
            ST_FITW: begin
                if (sts.div_done) begin
                    cmd.fit_take = 1'b1;
                    state_next   = ST_ZW;
                end
            end
            ST_ZW: begin
                cmd.zoom_w = 1'b1;
                state_next = ST_ZH;
            end
            ST_ZH: begin
                cmd.zoom_h = 1'b1;
                state_next = ST_OFS;
            end
            ST_OFS: begin
                cmd.ofs    = 1'b1;
                state_next = ST_NX;
            end
            ST_NX: begin
                cmd.num_x  = 1'b1;
                state_next = ST_DXS;
            end
            ST_DXS: begin
                cmd.div_x  = 1'b1;
                state_next = ST_DXW;
            end
            ST_DXW: begin
                if (sts.div_done) begin
                    cmd.col_take = 1'b1;
                    state_next   = ST_NY;
                end
            end
            ST_NY: begin
                cmd.num_y  = 1'b1;
                state_next = ST_DYS;
            end
            ST_DYS: begin
                cmd.div_y  = 1'b1;
                state_next = ST_DYW;
            end
            ST_DYW: begin
                if (sts.div_done) begin
                    cmd.row_take = 1'b1;
                    state_next   = ST_OUTW;
                end
            end
            ST_OUTW: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_SQX)
        else $error("accepted item did not start");
    a_commit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> state_reg == ST_IDLE && s_tready)
        else $error("commit not followed by idle");
    a_wait_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FITW && !sts.div_done |=> state_reg == ST_FITW)
        else $error("left fit wait before divider done");

endmodule

`default_nettype wire

/* hw/rtl/touch_gesture_classifier_top.sv */
// top level of the touch gesture classifier: stream ports, config port
// depends on tgc_pkg, tgc_ctrl, tgc_dp (with tgc_div)
`default_nettype none

// Each accepted touch item gives exactly one result item. An item that needs
// no cell mapping goes through the square and tangent steps and then waits for
// the output register. An item that maps a position to a grid cell (hover,
// tap, long press, inspect release) also sends the fit width, the column and
// the row each through one shared restoring divider at one quotient bit per
// cycle, plus steps on one shared multiplier. One item is worked on at a time;
// the next item is taken while the previous result still waits in the output
// register. Config writes are taken every cycle and belong in idle periods.

module touch_gesture_classifier_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // finger_id, pos_x, pos_y, stamp_ms
    input  wire logic [2:0]  s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // valid_res, arg_one, arg_two, pan_override
    output logic [2:0]       m_tuser,   // event_kind
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    tgc_pkg::cmd_t cmd;
    tgc_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    tgc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tgc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

/* dv/tb_touch_gesture_classifier_top.sv */
// testbench for touch_gesture_classifier_top: random and directed touch items,
// predicted results checked item by item; depends on tgc_pkg and the rtl
`timescale 1ns / 1ps

module tb_touch_gesture_classifier_top;
    import tgc_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_DOWN, ST_SWIPE, ST_INSPECT, ST_TWO} touch_st_e;

    typedef struct {
        logic [2:0]  mode;
        logic [15:0] fid;
        logic [11:0] px;
        logic [11:0] py;
        logic [31:0] stamp;
    } touch_t;

    typedef struct {
        logic       vld;
        logic [2:0] kind;
        logic [7:0] a1;
        logic [7:0] a2;
        logic       pan;
    } pointer_ev_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    touch_gesture_classifier_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // predictor copy of config and gesture state
    int unsigned win_w, win_h, zoom, ui_on, long_ms, tap_max, swipe_min, two_ms;
    touch_st_e   gst;
    int          start_x, start_y;
    logic [31:0] start_t;
    logic [15:0] id_one, id_two;
    int          f1x, f1y, f2x, f2y, midx, midy, panx, pany;
    logic        pan_hold, owed;
    int          owed_c, owed_r;

    touch_t      touch_q[$];
    pointer_ev_t event_q[$];
    int          errors = 0;
    int unsigned tx_idle_pct = 0, rx_stall_pct = 0;
    int          hold_ask = 0, hold_done = 0, hold_left = 0;
    logic        s_took = 0;
    logic [31:0] now_ms;

    function automatic int axis_cell(longint p, longint ofs, longint len, longint n);
        longint num, q;
        num = (p - ofs) * n;
        if (num < 0) return 0;
        q = num / len;
        if (q >= n) q = n - 1;
        return int'(q);
    endfunction

    function automatic void map_cell(input int px, input int py, output int cx, output int cy);
        longint ww, hh, fw, fh, w, h, ox, oy, z;
        ww = win_w != 0 ? win_w : 1;
        hh = win_h != 0 ? win_h : 1;
        fw = hh * 16 / 10;
        fh = hh;
        if (fw > ww) begin
            fw = ww;
            fh = ww * 10 / 16;
        end
        if (fw < 1) fw = 1;
        if (fh < 1) fh = 1;
        if (ui_on != 0) begin
            w = fw;
            h = fh;
            ox = (ww - w) / 2;
            oy = (hh - h) / 2;
        end else begin
            z = zoom < 256 ? 256 : zoom;
            w = (fw * z) >>> 8;
            h = (fh * z) >>> 8;
            ox = (ww - w) / 2 + longint'(panx) / 2;
            oy = (hh - h) / 2 + longint'(pany) / 2;
            if (ox > 0) ox = 0;
            if (oy > 0) oy = 0;
            if (ox + w < ww) ox = ww - w;
            if (oy + h < hh) oy = hh - h;
        end
        cx = axis_cell(px, ox, w, GRID_COLS);
        cy = axis_cell(py, oy, h, GRID_ROWS);
    endfunction

    function automatic longint dist_sq(int x0, int y0, int x1, int y1);
        longint dx, dy;
        dx = x1 - x0;
        dy = y1 - y0;
        return dx * dx + dy * dy;
    endfunction

    function automatic logic [7:0] swipe_dir(longint ux, longint uy);
        longint ax, ay;
        ax = ux < 0 ? -ux : ux;
        ay = uy < 0 ? -uy : uy;
        if ((ax == 0 && ay == 0) || ay * 65536 < ax * TAN_Q16)
            return ux < 0 ? KEY_W : KEY_E;
        if (ax * 65536 <= ay * TAN_Q16)
            return uy > 0 ? KEY_N : KEY_S;
        if (ux > 0) return uy > 0 ? KEY_NE : KEY_SE;
        return uy > 0 ? KEY_NW : KEY_SW;
    endfunction

    function automatic int pan_sat(int p, longint d);
        longint v;
        v = p + d;
        if (v > 65535) v = 65535;
        if (v < -65536) v = -65536;
        return int'(v);
    endfunction

    function automatic pointer_ev_t predict_event(touch_t t);
        pointer_ev_t r;
        logic [31:0] elapsed;
        longint      tap_sq, swp_sq;
        int          px, py, c, rw;
        px = t.px;
        py = t.py;
        elapsed = t.stamp - start_t;
        tap_sq = longint'(tap_max) * tap_max;
        swp_sq = longint'(swipe_min) * swipe_min;
        r = '{1'b0, EV_DOWN, 8'd0, 8'd0, 1'b0};
        if (t.mode == MODE_RESET) begin
            gst = ST_IDLE;
            owed = 0;
        end else if (owed) begin
            owed = 0;
            r.vld = 1; r.kind = EV_UP; r.a1 = owed_c; r.a2 = owed_r;
        end else if (t.mode == MODE_DOWN) begin
            if (gst == ST_IDLE) begin
                gst = ST_DOWN;
                id_one = t.fid; start_x = px; start_y = py; start_t = t.stamp;
            end else if (gst == ST_DOWN) begin
                gst = ST_TWO;
                pan_hold = 1;
                id_two = t.fid;
                f1x = start_x; f1y = start_y; f2x = px; f2y = py;
                midx = start_x + px; midy = start_y + py;
            end
        end else if (t.mode == MODE_MOVE) begin
            if (gst == ST_DOWN && t.fid == id_one) begin
                if (elapsed >= long_ms) begin
                    gst = ST_INSPECT;
                    map_cell(px, py, c, rw);
                    r.vld = 1; r.kind = EV_HOVER; r.a1 = c; r.a2 = rw;
                end else if (dist_sq(start_x, start_y, px, py) > tap_sq) begin
                    gst = ST_SWIPE;
                end
            end else if (gst == ST_INSPECT && t.fid == id_one) begin
                map_cell(px, py, c, rw);
                r.vld = 1; r.kind = EV_HOVER; r.a1 = c; r.a2 = rw;
            end else if (gst == ST_TWO) begin
                if (t.fid == id_one) begin
                    f1x = px; f1y = py;
                end else if (t.fid == id_two) begin
                    f2x = px; f2y = py;
                end
                panx = pan_sat(panx, longint'(f1x + f2x) - midx);
                pany = pan_sat(pany, longint'(f1y + f2y) - midy);
                midx = f1x + f2x;
                midy = f1y + f2y;
            end
        end else if (t.mode == MODE_UP) begin
            if (gst == ST_DOWN && t.fid == id_one) begin
                if (dist_sq(start_x, start_y, px, py) <= tap_sq) begin
                    map_cell(start_x, start_y, c, rw);
                    r.vld = 1; r.a1 = c; r.a2 = rw;
                    if (elapsed >= long_ms) r.kind = EV_RDOWN;
                    else begin
                        r.kind = EV_DOWN;
                        owed = 1; owed_c = c; owed_r = rw;
                    end
                end
            end else if (gst == ST_SWIPE && t.fid == id_one) begin
                if (dist_sq(start_x, start_y, px, py) >= swp_sq) begin
                    r.vld = 1; r.kind = EV_KEY;
                    r.a1 = swipe_dir(longint'(px) - start_x, longint'(start_y) - py);
                end
            end else if (gst == ST_INSPECT && t.fid == id_one) begin
                map_cell(px, py, c, rw);
                r.vld = 1; r.kind = EV_DOWN; r.a1 = c; r.a2 = rw;
                owed = 1; owed_c = c; owed_r = rw;
            end else if (gst == ST_TWO) begin
                pan_hold = 0;
                if (elapsed <= two_ms) begin
                    r.vld = 1; r.kind = EV_KEY; r.a1 = KEY_ESC;
                end
            end
            gst = ST_IDLE;
        end
        r.pan = pan_hold;
        return r;
    endfunction

    // sender
    always @(negedge aclk) begin
        touch_t t;
        if (aresetn && (!s_tvalid || s_took)) begin
            if (touch_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                t = touch_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= t.mode;
                s_tdata <= {t.stamp, t.py, t.px, t.fid};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with an occasional long hold-off
    always @(negedge aclk) begin
        if (hold_ask != hold_done) begin
            hold_done <= hold_ask;
            hold_left <= 400;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        touch_t      t;
        pointer_ev_t e;
        if (aresetn) begin
            s_took <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                t.fid = s_tdata[15:0];
                t.px = s_tdata[27:16];
                t.py = s_tdata[39:28];
                t.stamp = s_tdata[71:40];
                t.mode = s_tuser;
                event_q.push_back(predict_event(t));
            end
            if (m_tvalid && m_tready) begin
                if (event_q.size() == 0) begin
                    $error("result item with no expectation: %h %h", m_tdata, m_tuser);
                    errors++;
                end else begin
                    e = event_q.pop_front();
                    if (m_tdata[0] !== e.vld) begin
                        $error("valid_res exp %0d got %0d", e.vld, m_tdata[0]);
                        errors++;
                    end
                    if (m_tuser !== e.kind) begin
                        $error("event_kind exp %0d got %0d", e.kind, m_tuser);
                        errors++;
                    end
                    if (m_tdata[8:1] !== e.a1) begin
                        $error("arg_one exp %0d got %0d", e.a1, m_tdata[8:1]);
                        errors++;
                    end
                    if (m_tdata[16:9] !== e.a2) begin
                        $error("arg_two exp %0d got %0d", e.a2, m_tdata[16:9]);
                        errors++;
                    end
                    if (m_tdata[17] !== e.pan) begin
                        $error("pan_override exp %0d got %0d", e.pan, m_tdata[17]);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic int clip(int v);
        return v < 0 ? 0 : (v > 4095 ? 4095 : v);
    endfunction

    function automatic int jit(int v, int r);
        return clip(v + int'($urandom_range(0, 2 * r)) - r);
    endfunction

    function automatic void add_touch(logic [2:0] mode, int id, int x, int y, int unsigned dt);
        touch_t t;
        now_ms = now_ms + dt;
        t.mode = mode; t.fid = id; t.px = x; t.py = y; t.stamp = now_ms;
        touch_q.push_back(t);
    endfunction

    function automatic int rnd_id();
        return $urandom_range(0, 65535);
    endfunction

    function automatic int rnd_px();
        return $urandom_range(0, 4095);
    endfunction

    function automatic void add_gesture();
        int unsigned pick, n;
        int          id, id2, x, y, dx, dy;
        pick = $urandom_range(0, 99);
        id = rnd_id();
        id2 = rnd_id();
        x = rnd_px();
        y = rnd_px();
        if (pick < 20) begin
            add_touch(MODE_DOWN, id, x, y, $urandom_range(0, 50));
            add_touch(MODE_UP, id, jit(x, 30), jit(y, 30), $urandom_range(0, 600));
            add_touch($urandom_range(0, 3), rnd_id(), rnd_px(), rnd_px(), 5);
        end else if (pick < 40) begin
            add_touch(MODE_DOWN, id, x, y, $urandom_range(0, 50));
            add_touch(MODE_MOVE, id, jit(x, 10), jit(y, 10), long_ms + $urandom_range(0, 200));
            n = $urandom_range(0, 4);
            repeat (n) add_touch(MODE_MOVE, id, rnd_px(), rnd_px(), 10);
            add_touch(MODE_UP, id, rnd_px(), rnd_px(), 10);
            add_touch(MODE_POLL, rnd_id(), rnd_px(), rnd_px(), 5);
        end else if (pick < 60) begin
            dx = int'($urandom_range(0, 1200)) - 600;
            dy = int'($urandom_range(0, 1200)) - 600;
            add_touch(MODE_DOWN, id, x, y, $urandom_range(0, 50));
            add_touch(MODE_MOVE, id, clip(x + dx / 2), clip(y + dy / 2), 20);
            add_touch(MODE_UP, id, clip(x + dx), clip(y + dy), 20);
        end else if (pick < 82) begin
            add_touch(MODE_DOWN, id, x, y, $urandom_range(0, 50));
            add_touch(MODE_DOWN, id2, rnd_px(), rnd_px(), $urandom_range(0, 30));
            n = $urandom_range(1, 20);
            repeat (n)
                add_touch(MODE_MOVE, ($urandom_range(0, 9) < 5) ? id :
                          (($urandom_range(0, 9) < 8) ? id2 : rnd_id()),
                          rnd_px(), rnd_px(), $urandom_range(0, 15));
            add_touch(MODE_UP, $urandom_range(0, 1) ? id : id2, rnd_px(), rnd_px(),
                      $urandom_range(0, 300));
        end else if (pick < 88) begin
            add_touch(MODE_RESET, rnd_id(), rnd_px(), rnd_px(), $urandom_range(0, 100));
        end else begin
            add_touch($urandom_range(0, 7), rnd_id(), rnd_px(), rnd_px(),
                      $urandom_range(0, 1000));
        end
    endfunction

    function automatic void add_directed();
        add_touch(MODE_DOWN, 0, 0, 0, 0);
        add_touch(MODE_UP, 0, 0, 0, 10);
        add_touch(MODE_POLL, 0, 0, 0, 5);
        add_touch(MODE_DOWN, 65535, 4095, 4095, 10);
        add_touch(MODE_UP, 65535, 4095, 4095, 10);
        add_touch(MODE_RESET, 0, 0, 0, 5);
        add_touch(MODE_DOWN, 7, 500, 500, 10);
        add_touch(MODE_UP, 7, 505, 505, 1000);
        add_touch(MODE_DOWN, 9, 800, 400, 10);
        add_touch(MODE_MOVE, 9, 800, 400, 500);
        add_touch(MODE_UP, 9, 900, 420, 10);
        add_touch(3'd5, 1, 1, 1, 5);
        add_touch(MODE_DOWN, 3, 1000, 1000, 10);
        add_touch(MODE_MOVE, 3, 1200, 900, 10);
        add_touch(MODE_UP, 3, 1300, 850, 10);
        add_touch(MODE_DOWN, 4, 100, 100, 10);
        add_touch(MODE_DOWN, 5, 300, 300, 10);
        add_touch(MODE_DOWN, 6, 600, 300, 10);
        add_touch(MODE_MOVE, 5, 4095, 4095, 10);
        add_touch(MODE_UP, 4, 0, 0, 10);
        add_touch(MODE_DOWN, 11, 2000, 2000, 10);
        add_touch(MODE_UP, 12, 2000, 2000, 10);
        add_touch(3'd6, 2, 2, 2, 5);
        add_touch(3'd7, 3, 3, 3, 5);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input int unsigned val);
        logic got;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[15:0];
        forever begin
            @(negedge aclk);
            got = cfg_ready;
            @(posedge aclk);
            if (got) break;
        end
        case (idx)
            CFG_WIN_W:   win_w = val & 12'hFFF;
            CFG_WIN_H:   win_h = val & 12'hFFF;
            CFG_ZOOM:    zoom = val & 12'hFFF;
            CFG_UI:      ui_on = val & 1;
            CFG_LONG:    long_ms = val & 16'hFFFF;
            CFG_TAP:     tap_max = val & 12'hFFF;
            CFG_SWIPE:   swipe_min = val & 12'hFFF;
            default:     two_ms = val & 16'hFFFF;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(int unsigned w, int unsigned h, int unsigned z, int unsigned u,
                            int unsigned lp, int unsigned tp, int unsigned sw,
                            int unsigned tt);
        write_reg(CFG_WIN_W, w);
        write_reg(CFG_WIN_H, h);
        write_reg(CFG_ZOOM, z);
        write_reg(CFG_UI, u);
        write_reg(CFG_LONG, lp);
        write_reg(CFG_TAP, tp);
        write_reg(CFG_SWIPE, sw);
        write_reg(CFG_TWO_TAP, tt);
    endtask

    task automatic run_phase(int unsigned tx, int unsigned rx, bit hold, bit directed);
        tx_idle_pct = tx;
        rx_stall_pct = rx;
        if (directed) add_directed();
        while (touch_q.size() < 230) add_gesture();
        if (hold) begin
            @(posedge aclk);
            hold_ask = hold_ask + 1;
        end
        while (touch_q.size() > 0 || s_tvalid || event_q.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    initial begin
        win_w = 1920; win_h = 1080; zoom = 512; ui_on = 0;
        long_ms = 400; tap_max = 20; swipe_min = 40; two_ms = 200;
        gst = ST_IDLE;
        start_x = 0; start_y = 0; start_t = 0; id_one = 0; id_two = 0;
        f1x = 0; f1y = 0; f2x = 0; f2y = 0; midx = 0; midy = 0; panx = 0; pany = 0;
        pan_hold = 0; owed = 0; owed_c = 0; owed_r = 0;
        now_ms = $urandom;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (5) @(posedge aclk);

        run_phase(0, 0, 0, 1);
        set_regs(4095, 4095, 4095, 0, 0, 0, 0, 0);
        run_phase(85, 0, 0, 0);
        set_regs(1, 1, 256, 1, 65535, 4095, 4095, 65535);
        run_phase(0, 85, 0, 0);
        set_regs(0, 0, 0, 0, 400, 20, 40, 200);
        run_phase(8, 8, 1, 0);
        set_regs(800, 2000, 300, 0, 150, 60, 100, 120);
        run_phase(0, 0, 1, 0);
        set_regs(2000, 300, 1000, 1, 300, 15, 30, 250);
        run_phase(8, 8, 0, 0);

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
